@@ design/anbs_pkg.sv @@
// Package for the Annex B NAL unit splitter: result and push types, fixed widths
// and start-code constants.
// No dependencies; every other file of the block refers to it by scoped names.
package anbs_pkg;

  // Fixed field widths of the channels.
  localparam int BYTE_W = 8;
  localparam int ZCNT_W = 16;

  // A start code is at least this many zero bytes followed by START_BYTE.
  localparam int             MIN_SC_ZEROS = 2;
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h01;

  // Result queue between the splitter core and the output channel.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ZCNT_W-1:0] zcnt_t;

  // One result item as it leaves the block.
  typedef struct packed {
    byte_t nal_byte;
    zcnt_t zeros_before;
    logic  zeros_saturated;
    logic  byte_valid;
    logic  nal_first;
    logic  nal_last;
    logic  unit_done;
    logic  unit_ok;
  } anbs_result_t;

  // Results produced by one input byte: count, then up to two items in order.
  typedef struct packed {
    logic [1:0]   n;
    anbs_result_t a;
    anbs_result_t b;
  } anbs_push_t;

endpackage

@@ design/anbs_in_if.sv @@
// Input byte channel of the Annex B NAL unit splitter: valid/ready plus one stream byte.
// Depends on anbs_pkg for the byte type.
interface anbs_in_if;
  logic             valid;
  logic             ready;
  anbs_pkg::byte_t  stream_byte;
  logic             unit_last;

  modport source (output valid, output stream_byte, output unit_last, input ready);
  modport sink   (input valid, input stream_byte, input unit_last, output ready);
endinterface

@@ design/anbs_out_if.sv @@
// Result channel of the Annex B NAL unit splitter: valid/ready plus one result item.
// Depends on anbs_pkg for the field types.
interface anbs_out_if;
  logic             valid;
  logic             ready;
  anbs_pkg::byte_t  nal_byte;
  anbs_pkg::zcnt_t  zeros_before;
  logic             zeros_saturated;
  logic             byte_valid;
  logic             nal_first;
  logic             nal_last;
  logic             unit_done;
  logic             unit_ok;

  modport source (
    output valid, output nal_byte, output zeros_before, output zeros_saturated,
    output byte_valid, output nal_first, output nal_last, output unit_done,
    output unit_ok, input ready
  );
  modport sink (
    input valid, input nal_byte, input zeros_before, input zeros_saturated,
    input byte_valid, input nal_first, input nal_last, input unit_done,
    input unit_ok, output ready
  );
endinterface

@@ design/anbs_core.sv @@
// Splitter core: input register, start-code detection, zero counting and the held byte.
// Depends on anbs_pkg and anbs_in_if; hands up to two results per byte to the queue.
module anbs_core #(
  parameter int ZERO_RUN_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  anbs_in_if.sink             in_chan,
  input  logic                room,
  output anbs_pkg::anbs_push_t push
);

  localparam int RUN_W = (ZERO_RUN_BITS < anbs_pkg::ZCNT_W) ? ZERO_RUN_BITS
                                                             : anbs_pkg::ZCNT_W;
  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  // Input register.
  logic            in_vld_r;
  anbs_pkg::byte_t in_byte_r;
  logic            in_last_r;

  // Parser state and its next values.
  logic             inside_r,     inside_nxt;
  logic [RUN_W-1:0] zero_run_r,   zero_run_nxt;
  logic             clamp_r,      clamp_nxt;
  anbs_pkg::byte_t  held_byte_r,  held_byte_nxt;
  anbs_pkg::zcnt_t  held_zeros_r, held_zeros_nxt;
  logic             held_clamp_r, held_clamp_nxt;
  logic             held_vld_r,   held_vld_nxt;
  logic             held_first_r, held_first_nxt;
  logic             found_r,      found_nxt;

  logic                   fire;
  logic                   is_zero;
  logic                   is_start;
  logic                   pre_emit;
  anbs_pkg::anbs_result_t pre_res;
  anbs_pkg::anbs_result_t fin_res;
  anbs_pkg::anbs_push_t   step_push;

  function automatic anbs_pkg::anbs_result_t held_res(
    input anbs_pkg::byte_t b,
    input anbs_pkg::zcnt_t z,
    input logic            clamp,
    input logic            first,
    input logic            last
  );
    anbs_pkg::anbs_result_t r;
    r                 = '0;
    r.nal_byte        = b;
    r.zeros_before    = z;
    r.zeros_saturated = clamp;
    r.byte_valid      = 1'b1;
    r.nal_first       = first;
    r.nal_last        = last;
    return r;
  endfunction

  // A byte leaves the input register once the queue can take two results.
  assign fire          = in_vld_r & room;
  assign in_chan.ready = ~in_vld_r | room;

  // Input register load and release.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.stream_byte;
      in_last_r <= in_chan.unit_last;
    end
  end

  assign is_zero  = (in_byte_r == '0);
  assign is_start = (in_byte_r == anbs_pkg::START_BYTE) &&
                    (zero_run_r >= RUN_W'(anbs_pkg::MIN_SC_ZEROS));

  // One parsing step for the byte in the input register.
  always_comb begin
    inside_nxt     = inside_r;
    zero_run_nxt   = zero_run_r;
    clamp_nxt      = clamp_r;
    held_byte_nxt  = held_byte_r;
    held_zeros_nxt = held_zeros_r;
    held_clamp_nxt = held_clamp_r;
    held_vld_nxt   = held_vld_r;
    held_first_nxt = held_first_r;
    found_nxt      = found_r;
    pre_emit       = 1'b0;
    pre_res        = '0;

    if (is_zero) begin
      // Count zeros; at the limit the count sticks and the clamp flag is set.
      if (zero_run_r == RUN_MAX) begin
        clamp_nxt = 1'b1;
      end else begin
        zero_run_nxt = zero_run_r + RUN_W'(1);
      end
    end else if (is_start) begin
      // Start code closes the current NAL and opens a new one.
      if (held_vld_r) begin
        pre_emit = 1'b1;
        pre_res  = held_res(held_byte_r, held_zeros_r, held_clamp_r, held_first_r, 1'b1);
      end
      held_vld_nxt   = 1'b0;
      held_first_nxt = 1'b0;
      inside_nxt     = 1'b1;
      zero_run_nxt   = '0;
      clamp_nxt      = 1'b0;
    end else begin
      // Data byte: release the held byte and hold this one with its zero run.
      if (inside_r) begin
        if (held_vld_r) begin
          pre_emit = 1'b1;
          pre_res  = held_res(held_byte_r, held_zeros_r, held_clamp_r, held_first_r, 1'b0);
        end
        held_byte_nxt  = in_byte_r;
        held_zeros_nxt = anbs_pkg::zcnt_t'(zero_run_r);
        held_clamp_nxt = clamp_r;
        held_vld_nxt   = 1'b1;
        held_first_nxt = ~held_vld_r;
        found_nxt      = 1'b1;
      end
      zero_run_nxt = '0;
      clamp_nxt    = 1'b0;
    end

    // Final result of the access unit: the held byte, or an empty marker.
    if (held_vld_nxt) begin
      fin_res = held_res(held_byte_nxt, held_zeros_nxt, held_clamp_nxt, held_first_nxt, 1'b1);
    end else begin
      fin_res = '0;
    end
    fin_res.unit_done = 1'b1;
    fin_res.unit_ok   = found_nxt;

    step_push   = '0;
    step_push.a = pre_res;
    step_push.b = fin_res;
    step_push.n = {1'b0, pre_emit};
    if (in_last_r) begin
      if (held_vld_nxt || !pre_emit) begin
        if (pre_emit) begin
          step_push.n = 2'd2;
        end else begin
          step_push.a = fin_res;
          step_push.n = 2'd1;
        end
      end else begin
        // The released byte is the last result and carries the unit status.
        step_push.a.unit_done = 1'b1;
        step_push.a.unit_ok   = found_nxt;
      end
      // All state returns to reset after the final byte.
      inside_nxt     = 1'b0;
      zero_run_nxt   = '0;
      clamp_nxt      = 1'b0;
      held_byte_nxt  = '0;
      held_zeros_nxt = '0;
      held_clamp_nxt = 1'b0;
      held_vld_nxt   = 1'b0;
      held_first_nxt = 1'b0;
      found_nxt      = 1'b0;
    end
  end

  // Push results only when the step commits.
  always_comb begin
    push = step_push;
    if (!fire) begin
      push.n = 2'd0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r     <= 1'b0;
      zero_run_r   <= '0;
      clamp_r      <= 1'b0;
      held_vld_r   <= 1'b0;
      held_first_r <= 1'b0;
      found_r      <= 1'b0;
    end else if (fire) begin
      inside_r     <= inside_nxt;
      zero_run_r   <= zero_run_nxt;
      clamp_r      <= clamp_nxt;
      held_vld_r   <= held_vld_nxt;
      held_first_r <= held_first_nxt;
      found_r      <= found_nxt;
    end
  end

  // Held byte payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      held_byte_r  <= held_byte_nxt;
      held_zeros_r <= held_zeros_nxt;
      held_clamp_r <= held_clamp_nxt;
    end
  end

  // Two results per byte only happen at unit end, data first, status second.
  a_two_results_end: assert property (@(posedge clk) disable iff (!rst_n)
    push.n == 2'd2 |-> push.b.unit_done && push.a.byte_valid && !push.a.unit_done)
    else $error("two results without a trailing unit end");

  // The last byte of a unit leaves the parser in its reset state.
  a_unit_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_last_r |=> !held_vld_r && !inside_r && !found_r && zero_run_r == '0)
    else $error("parser state not cleared after unit end");

  // Results are pushed only when the queue has reserved room.
  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> room)
    else $error("results pushed without queue room");

endmodule

@@ design/anbs_out_fifo.sv @@
// Result queue: takes up to two results per cycle from the core, drives one per transfer.
// Depends on anbs_pkg and anbs_out_if.
module anbs_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  anbs_pkg::anbs_push_t push,
  output logic                 room,
  anbs_out_if.source           out_chan
);

  localparam int PTR_W = anbs_pkg::FIFO_PTR_W;
  localparam int CNT_W = anbs_pkg::FIFO_CNT_W;

  anbs_pkg::anbs_result_t mem [anbs_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r,  count_nxt;
  logic                   pop;
  anbs_pkg::anbs_result_t head;

  // Room for a worst-case byte (two results), counting from the registered level.
  assign room = (count_r <= CNT_W'(anbs_pkg::FIFO_DEPTH - 2));
  assign pop  = out_chan.valid & out_chan.ready;

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.n);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + CNT_W'(push.n) - CNT_W'(pop);

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry writes: first result at the tail, second right after it.
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr_r] <= push.a;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_r + PTR_W'(1)] <= push.b;
    end
  end

  // Head of the queue drives the result channel.
  assign head                     = mem[rd_ptr_r];
  assign out_chan.valid           = (count_r != '0);
  assign out_chan.nal_byte        = head.nal_byte;
  assign out_chan.zeros_before    = head.zeros_before;
  assign out_chan.zeros_saturated = head.zeros_saturated;
  assign out_chan.byte_valid      = head.byte_valid;
  assign out_chan.nal_first       = head.nal_first;
  assign out_chan.nal_last        = head.nal_last;
  assign out_chan.unit_done       = head.unit_done;
  assign out_chan.unit_ok         = head.unit_ok;

  // The fill level never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(anbs_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // A push lands only when at least two entries are free.
  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |-> count_r <= CNT_W'(anbs_pkg::FIFO_DEPTH - 2))
    else $error("push into a nearly full queue");

  // A transfer with no push lowers the level by exactly one.
  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && push.n == 2'd0 |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("queue level did not drop after a transfer");

endmodule

@@ design/annexb_nal_unit_splitter.sv @@
// Channel   | Dir | Handshake    | Payload
// in_chan   | in  | valid/ready  | stream_byte[7:0], unit_last
// out_chan  | out | valid/ready  | nal_byte[7:0], zeros_before[15:0], zeros_saturated,
//           |     |              | byte_valid, nal_first, nal_last, unit_done, unit_ok
//
// One byte is taken per clock while the queue has room. A byte is held in the input
// register, where the parser step runs, and its results are then written into the
// four-entry result queue, whose head is offered on out_chan.
// The input stalls while the queue holds more than two results (room for a worst-case
// byte, which yields two). rst_n is synchronous and active low; it empties both stages
// and returns the parser to the start of an access unit.
//
// Top level of the Annex B NAL unit splitter; depends on anbs_pkg, anbs_in_if,
// anbs_out_if, anbs_core and anbs_out_fifo.
module annexb_nal_unit_splitter #(
  parameter int ZERO_RUN_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  anbs_in_if.sink    in_chan,
  anbs_out_if.source out_chan
);

  anbs_pkg::anbs_push_t push;
  logic                 room;

  // Parser core with its input register.
  anbs_core #(
    .ZERO_RUN_BITS (ZERO_RUN_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .room    (room),
    .push    (push)
  );

  // Result queue feeding the output channel.
  anbs_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule

@@ dv/annexb_nal_unit_splitter_tb.sv @@
// Self-checking testbench for annexb_nal_unit_splitter: directed and random access units,
// checked result by result against a scoreboard that tracks the splitter state itself.
// Depends on anbs_pkg, anbs_in_if, anbs_out_if and the splitter RTL.
`timescale 1ns / 100ps

module annexb_nal_unit_splitter_tb;

  localparam int unsigned ZRB = 16;
  // Largest zero count the splitter can hold before it clamps.
  localparam int unsigned RUN_LIMIT = (ZRB >= 16) ? 32'hFFFF : ((32'd1 << ZRB) - 1);
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned ITEMS_PER_PHASE = 80;
  localparam int unsigned MAX_PRINTED = 50;

  // Scoreboard: follows the splitter state per accepted byte and holds expected results.
  class nal_split_scoreboard;
    int unsigned run_limit;
    bit in_nal;
    int unsigned zero_run;
    bit run_clamped;
    anbs_pkg::anbs_result_t held;
    bit held_valid;
    bit found_nal;
    anbs_pkg::anbs_result_t expected_results[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned units;
    int unsigned empty_units;
    int unsigned nal_units;
    int unsigned clamped_runs;

    function new(int unsigned limit);
      run_limit = limit;
      clear_state();
    endfunction

    function void clear_state();
      in_nal = 1'b0;
      zero_run = 0;
      run_clamped = 1'b0;
      held = '0;
      held_valid = 1'b0;
      found_nal = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Queue a result; the coverage counts are kept by the caller.
    function void push_result(anbs_pkg::anbs_result_t r);
      expected_results.push_back(r);
    endfunction

    // Work out what one accepted byte produces.
    function void note_byte(anbs_pkg::byte_t b, logic unit_last);
      anbs_pkg::anbs_result_t outs[$];
      anbs_pkg::anbs_result_t r;
      bit first;
      if (b == 8'h00) begin
        if (zero_run >= run_limit) run_clamped = 1'b1;
        else zero_run++;
      end else if (b == anbs_pkg::START_BYTE && zero_run >= anbs_pkg::MIN_SC_ZEROS) begin
        // A start code closes the open NAL and opens the next one.
        if (held_valid) begin
          r = held;
          r.nal_last = 1'b1;
          outs.push_back(r);
        end
        held_valid = 1'b0;
        in_nal = 1'b1;
        zero_run = 0;
        run_clamped = 1'b0;
      end else begin
        // A data byte releases the previous one and is held back itself.
        if (in_nal) begin
          first = !held_valid;
          if (held_valid) outs.push_back(held);
          held = '0;
          held.nal_byte = b;
          held.zeros_before = anbs_pkg::zcnt_t'(zero_run);
          held.zeros_saturated = run_clamped;
          held.byte_valid = 1'b1;
          held.nal_first = first;
          held_valid = 1'b1;
          found_nal = 1'b1;
        end
        zero_run = 0;
        run_clamped = 1'b0;
      end

      // At the end of the unit the held byte goes out and the last result is tagged.
      if (unit_last) begin
        if (held_valid) begin
          r = held;
          r.nal_last = 1'b1;
          outs.push_back(r);
        end else if (outs.size() == 0) begin
          outs.push_back('0);
        end
        outs[outs.size() - 1].unit_done = 1'b1;
        outs[outs.size() - 1].unit_ok = found_nal;
        units++;
        if (!found_nal) empty_units++;
        clear_state();
      end

      foreach (outs[i]) begin
        if (outs[i].nal_first) nal_units++;
        if (outs[i].zeros_saturated) clamped_runs++;
        push_result(outs[i]);
      end
    endfunction

    task mismatch_report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch at result %0d: %s", $time, checked, msg);
    endtask

    // Compare one accepted result with the oldest expectation, field by field.
    task check_result(anbs_pkg::anbs_result_t got);
      anbs_pkg::anbs_result_t want;
      if (expected_results.size() == 0) begin
        mismatch_report($sformatf("result with none expected: %p", got));
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.nal_byte !== want.nal_byte)
        mismatch_report($sformatf("nal_byte %h, expected %h", got.nal_byte, want.nal_byte));
      if (got.zeros_before !== want.zeros_before)
        mismatch_report($sformatf("zeros_before %0d, expected %0d",
                                  got.zeros_before, want.zeros_before));
      if (got.zeros_saturated !== want.zeros_saturated)
        mismatch_report($sformatf("zeros_saturated %b, expected %b",
                                  got.zeros_saturated, want.zeros_saturated));
      if (got.byte_valid !== want.byte_valid)
        mismatch_report($sformatf("byte_valid %b, expected %b", got.byte_valid, want.byte_valid));
      if (got.nal_first !== want.nal_first)
        mismatch_report($sformatf("nal_first %b, expected %b", got.nal_first, want.nal_first));
      if (got.nal_last !== want.nal_last)
        mismatch_report($sformatf("nal_last %b, expected %b", got.nal_last, want.nal_last));
      if (got.unit_done !== want.unit_done)
        mismatch_report($sformatf("unit_done %b, expected %b", got.unit_done, want.unit_done));
      if (got.unit_ok !== want.unit_ok)
        mismatch_report($sformatf("unit_ok %b, expected %b", got.unit_ok, want.unit_ok));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  anbs_in_if  in_chan ();
  anbs_out_if out_chan ();

  annexb_nal_unit_splitter #(
    .ZERO_RUN_BITS(ZRB)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  nal_split_scoreboard sb = new(RUN_LIMIT);

  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned hold_requests;
  int unsigned holds_taken;
  int unsigned hold_left;
  int unsigned bytes_sent;
  int unsigned random_items;
  int unsigned cycles;

  always #1 clk = ~clk;

  // Watchdog: ends the run if it goes on far longer than any correct run would.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycles, sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

  // Monitor: every transfer on either channel goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) sb.note_byte(in_chan.stream_byte, in_chan.unit_last);
      if (out_chan.valid && out_chan.ready)
        sb.check_result('{nal_byte: out_chan.nal_byte, zeros_before: out_chan.zeros_before,
                          zeros_saturated: out_chan.zeros_saturated,
                          byte_valid: out_chan.byte_valid, nal_first: out_chan.nal_first,
                          nal_last: out_chan.nal_last, unit_done: out_chan.unit_done,
                          unit_ok: out_chan.unit_ok});
    end
  end

  // Receiver: random stalls, plus long hold-offs counted here on request.
  initial begin
    out_chan.ready = 1'b0;
    hold_left = 0;
    holds_taken = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (hold_requests != holds_taken) begin
        holds_taken = hold_requests;
        hold_left = HOLD_CYCLES - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // Offer one byte, with random idle cycles first, and return once it is transferred.
  task send_byte(anbs_pkg::byte_t b, logic unit_last);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.stream_byte <= b;
    in_chan.unit_last <= unit_last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send a byte sequence; the final byte closes the unit when ends_unit is set.
  task send_seq(anbs_pkg::byte_t q[$], bit ends_unit);
    foreach (q[i]) send_byte(q[i], ends_unit && (i == q.size() - 1));
  endtask

  // Payload content: zeros and 01 often enough to form runs and embedded start codes.
  function anbs_pkg::byte_t payload_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return 8'h00;
    if (r < 45) return anbs_pkg::START_BYTE;
    return anbs_pkg::byte_t'($urandom_range(255));
  endfunction

  // One random access unit: mostly well-formed NAL sequences, sometimes plain noise.
  task send_random_unit();
    anbs_pkg::byte_t q[$];
    int unsigned garbage;
    int unsigned nals;
    int unsigned len;
    if ($urandom_range(99) < 15) begin
      len = $urandom_range(1, 6);
      repeat (len) q.push_back(payload_byte());
      send_seq(q, 1'b1);
    end else begin
      garbage = $urandom_range(0, 2);
      repeat (garbage) q.push_back(anbs_pkg::byte_t'($urandom_range(2, 255)));
      nals = $urandom_range(1, 3);
      repeat (nals) begin
        repeat ($urandom_range(anbs_pkg::MIN_SC_ZEROS, 4)) q.push_back(8'h00);
        q.push_back(anbs_pkg::START_BYTE);
        len = ($urandom_range(99) < 5) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        repeat (len) q.push_back(payload_byte());
        repeat ($urandom_range(0, 2)) q.push_back(8'h00);
      end
      random_items += q.size() - garbage;
      send_seq(q, 1'b1);
    end
  endtask

  // Short units for the corner cases of the parser.
  task run_directed();
    anbs_pkg::byte_t q[$];
    // Leading bytes dropped, a lone zero before 01 is no start code, three-zero start code,
    // trailing zeros dropped with the final byte itself a zero.
    q = {8'h55, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h80,
         8'h00, 8'h00, 8'h00, 8'h01, 8'h7F, 8'h00, 8'h00};
    send_seq(q, 1'b1);
    // A unit without any start code.
    q = {8'h12, 8'hED};
    send_seq(q, 1'b1);
    // A one-byte unit.
    q = {8'h00};
    send_seq(q, 1'b1);
    // A start code as the final byte: empty NAL only.
    q = {8'h00, 8'h00, anbs_pkg::START_BYTE};
    send_seq(q, 1'b1);
    // Empty NAL dropped, then a final data byte that releases the held one.
    q = {8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'hAB, 8'h01};
    send_seq(q, 1'b1);
  endtask

  // Hold the receiver off while a long NAL streams in, so the input backs up.
  task run_backpressure();
    anbs_pkg::byte_t q[$];
    hold_requests++;
    q = {8'h00, 8'h00, anbs_pkg::START_BYTE};
    repeat (30) q.push_back(anbs_pkg::byte_t'($urandom_range(2, 255)));
    send_seq(q, 1'b1);
  endtask

  // Stimulus: reset, directed cases, then random phases with different idling.
  initial begin
    in_chan.valid = 1'b0;
    in_chan.stream_byte = '0;
    in_chan.unit_last = 1'b0;
    rst_n = 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_requests = 0;
    bytes_sent = 0;
    random_items = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 69; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 69; end
        default: begin in_idle_pct = 21; out_stall_pct = 21; end
      endcase
      while (random_items < (phase + 1) * ITEMS_PER_PHASE) send_random_unit();
      if (phase == 0) run_backpressure();
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d access units (%0d without a NAL); %0d results checked.",
             bytes_sent, sb.units, sb.empty_units, sb.checked);
    $display("Covered %0d NAL units, %0d clamped zero runs and one long receiver hold-off.",
             sb.nal_units, sb.clamped_runs);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
